>>> rtl/core/lics_pkg.sv
package lics_pkg;

   // Clamped channel width: a non-negative 16-bit signed sum kept in 15 bits.
   localparam int CHAN_W      = 15;
   // Numerator and aligned denominator width of the channel divider.
   localparam int NUM_W       = 23;
   // Quotient width: every rescaled channel lies in 0..255.
   localparam int QUO_W       = 8;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
   localparam int ADDR_W      = 14;
   localparam int ATLAS_WIDTH = 128;
   localparam int CHANNELS    = 3;

   localparam logic [QUO_W-1:0] FULL_SCALE  = 8'd255;
   localparam logic [15:0]      CHROMA_WHITE = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] red_sum;
      logic signed [15:0] green_sum;
      logic signed [15:0] blue_sum;
      logic [6:0]         atlas_x;
      logic [6:0]         atlas_y;
      logic [3:0]         atlas_select;
   } lics_req_type;

   typedef struct packed {
      logic [7:0]  intensity;
      logic [15:0] chroma;
      logic [3:0]  atlas_number;
      logic [13:0] luxel_address;
   } lics_rsp_type;

   // First stage: clamped channels, their maximum and the side fields.
   typedef struct packed {
      logic [CHANNELS-1:0][CHAN_W-1:0] chan;
      logic [CHAN_W-1:0]               peak;
      logic [3:0]                      atlas_number;
      logic [ADDR_W-1:0]               luxel_address;
   } lics_front_type;

   // Divider stage contents: partial remainders, the denominator aligned to
   // the next quotient bit, partial quotients and the fields that ride along.
   typedef struct packed {
      logic [CHANNELS-1:0][NUM_W-1:0]  rem;
      logic [NUM_W-1:0]                den;
      logic [CHANNELS-1:0][QUO_W-1:0]  quo;
      logic [7:0]                      intensity;
      logic                            white;
      logic [3:0]                      atlas_number;
      logic [ADDR_W-1:0]               luxel_address;
   } lics_div_type;

endpackage

>>> rtl/core/lics_div_stage.sv
module lics_div_stage (
   input  logic                 clock,
   input  logic                 enable,
   input  lics_pkg::lics_div_type src_stage,
   output lics_pkg::lics_div_type dst_stage
);
   import lics_pkg::*;

   lics_div_type stage_in;
   lics_div_type stage_ff;

   // Restoring division, two quotient bits per stage for all three channels.
   always_comb begin
      stage_in = src_stage;
      for (int s = 0; s < DIV_STEPS; s++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (stage_in.rem[c] >= stage_in.den) begin
               stage_in.rem[c] = stage_in.rem[c] - stage_in.den;
               stage_in.quo[c] = {stage_in.quo[c][QUO_W-2:0], 1'b1};
            end else begin
               stage_in.quo[c] = {stage_in.quo[c][QUO_W-2:0], 1'b0};
            end
         end
         stage_in.den = stage_in.den >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign dst_stage = stage_ff;

endmodule

>>> rtl/core/luxel_intensity_chroma_split_unit.sv
// Luxel intensity and chroma split.
//
// The req channel carries one item per luxel: signed red, green and blue
// light sums with the luxel's atlas position. The rsp channel returns one
// item per request, in order: an intensity byte (brightest clamped channel
// capped at 255, at least one), an RGB565 chroma rescaled so its brightest
// channel is full scale, the atlas number and the linear luxel address.
//
// The work runs through seven register stages: clamp and maximum, divider
// setup, four divider stages that each settle two quotient bits of all three
// channels, and the output register. An accepted item passes through them in
// that order to rsp, and one item can be accepted every cycle while req_stall
// is low; the throughput is one item per clock when nothing stalls.
//
// Each stage holds its item while the stage after it is full and stalled,
// so an empty stage keeps taking items while the receiver stalls; req_stall
// rises only once all seven stages hold items and rsp_stall is high.
// Reset empties the pipeline; items in flight are dropped.
module luxel_intensity_chroma_split_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lics_pkg::lics_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lics_pkg::lics_rsp_type rsp_data
);
   import lics_pkg::*;

   localparam int STAGES    = DIV_STAGES + 3;
   localparam int PREP_IDX  = 1;
   localparam int DIV0_IDX  = 2;
   localparam int OUT_IDX   = STAGES - 1;
   localparam int DIV_LAST  = OUT_IDX - 1;

   // Valid bit of every stage and the per-stage advance enables.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] ready;

   lics_front_type front_ff;
   lics_front_type front_in;
   lics_div_type   prep_in;
   lics_div_type   div_bus [DIV_STAGES+1];
   lics_rsp_type   out_ff;
   lics_rsp_type   out_in;

   logic [CHAN_W-1:0] clamp_r;
   logic [CHAN_W-1:0] clamp_g;
   logic [CHAN_W-1:0] clamp_b;
   logic [CHAN_W-1:0] peak_rg;
   logic              overbright;

   // A stage may load when it is empty or when its item moves on.
   always_comb begin
      ready[OUT_IDX] = !valid_ff[OUT_IDX] || !rsp_stall;
      for (int k = OUT_IDX - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage one: negative sums clamp to zero, then the brightest channel.
   always_comb begin
      clamp_r = req_data.red_sum[15]   ? '0 : req_data.red_sum[CHAN_W-1:0];
      clamp_g = req_data.green_sum[15] ? '0 : req_data.green_sum[CHAN_W-1:0];
      clamp_b = req_data.blue_sum[15]  ? '0 : req_data.blue_sum[CHAN_W-1:0];
      peak_rg = (clamp_r > clamp_g) ? clamp_r : clamp_g;
      front_in.chan[0]      = clamp_r;
      front_in.chan[1]      = clamp_g;
      front_in.chan[2]      = clamp_b;
      front_in.peak         = (clamp_b > peak_rg) ? clamp_b : peak_rg;
      front_in.atlas_number = req_data.atlas_select;
      front_in.luxel_address = ADDR_W'(32'(req_data.atlas_y) * 32'(ATLAS_WIDTH)
                                       + 32'(req_data.atlas_x));
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         front_ff <= front_in;
      end
   end

   // Stage two: set up the division. An overbright luxel is scaled by
   // 255/max with a floor; the rounded rescale then leaves it unchanged, so
   // the floor quotient is the chroma channel itself. Otherwise the chroma
   // channel is (510*c + max) / (2*max), a round-half-up of c*255/max.
   // Either way the quotient stays below 256, so eight bits settle it.
   always_comb begin
      overbright = front_ff.peak > CHAN_W'(FULL_SCALE);
      for (int c = 0; c < CHANNELS; c++) begin
         if (overbright) begin
            prep_in.rem[c] = NUM_W'({front_ff.chan[c], 8'b0})
                             - NUM_W'(front_ff.chan[c]);
         end else begin
            prep_in.rem[c] = NUM_W'({front_ff.chan[c][7:0], 9'b0})
                             - NUM_W'({front_ff.chan[c][7:0], 1'b0})
                             + NUM_W'(front_ff.peak[7:0]);
         end
         prep_in.quo[c] = '0;
      end
      if (overbright) begin
         prep_in.den       = NUM_W'({front_ff.peak, 7'b0});
         prep_in.intensity = FULL_SCALE;
      end else begin
         prep_in.den       = NUM_W'({front_ff.peak[7:0], 8'b0});
         prep_in.intensity = (front_ff.peak == '0) ? 8'd1 : front_ff.peak[7:0];
      end
      // With no light at all the color falls back to white.
      prep_in.white         = (front_ff.peak == '0);
      prep_in.atlas_number  = front_ff.atlas_number;
      prep_in.luxel_address = front_ff.luxel_address;
   end

   always_ff @(posedge clock) begin
      if (ready[PREP_IDX]) begin
         div_bus[0] <= prep_in;
      end
   end

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      lics_div_stage u_stage (
         .clock     (clock),
         .enable    (ready[DIV0_IDX+i]),
         .src_stage (div_bus[i]),
         .dst_stage (div_bus[i+1])
      );
   end

   // Output stage: pack the quotients as RGB565.
   always_comb begin
      out_in.intensity     = div_bus[DIV_STAGES].intensity;
      out_in.atlas_number  = div_bus[DIV_STAGES].atlas_number;
      out_in.luxel_address = div_bus[DIV_STAGES].luxel_address;
      if (div_bus[DIV_STAGES].white) begin
         out_in.chroma = CHROMA_WHITE;
      end else begin
         out_in.chroma = {div_bus[DIV_STAGES].quo[0][7:3],
                          div_bus[DIV_STAGES].quo[1][7:2],
                          div_bus[DIV_STAGES].quo[2][7:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (ready[OUT_IDX]) begin
         out_ff <= out_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[OUT_IDX];
   assign rsp_data  = out_ff;

   // The input only stalls when every stage is full and the receiver stalls.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled while the pipeline had room");

   // A delivered intensity is never zero.
   a_intensity_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.intensity != 8'd0))
      else $error("intensity of zero delivered");

   // The brightest channel always rescales to full scale.
   a_peak_full_scale: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_LAST] && !div_bus[DIV_STAGES].white) |->
         ((div_bus[DIV_STAGES].quo[0] == FULL_SCALE) ||
          (div_bus[DIV_STAGES].quo[1] == FULL_SCALE) ||
          (div_bus[DIV_STAGES].quo[2] == FULL_SCALE)))
      else $error("no chroma channel reached full scale");

   // An accepted item occupies the first stage in the next cycle.
   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted item lost at the first stage");

endmodule
